[hw/rtl/mmvr_pkg.sv]
// Shared types, codes and constants of the multi-mode vector reduction block.
`timescale 1ns / 1ps
package mmvr_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;

  localparam logic signed [47:0] SAT_HI  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SAT_LO  = 48'sh8000_0000_0000;
  localparam logic signed [47:0] ONE_Q16 = 48'sd65536;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_SUM    = 4'd1,
    OP_MEAN   = 4'd2,
    OP_STDEV  = 4'd3,
    OP_SSTDEV = 4'd4,
    OP_VAR    = 4'd5,
    OP_PROD   = 4'd6,
    OP_MAX    = 4'd7,
    OP_MIN    = 4'd8,
    OP_ARGMAX = 4'd9,
    OP_ARGMIN = 4'd10,
    OP_MEDIAN = 4'd11,
    OP_MODE   = 4'd12,
    OP_CNTNZ  = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_MODE = 2'd1,
    ERR_ONE  = 2'd2,
    ERR_OVF  = 2'd3
  } err_e;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic signed [47:0] result_value;
    logic [10:0]        result_count;
    logic [1:0]         error_code;
  } out_t;

endpackage

[hw/rtl/mmvr_store.sv]
// Sample memory: one write port and two registered read ports.
`timescale 1ns / 1ps
module mmvr_store #(
  parameter int unsigned Depth = mmvr_pkg::MAX_ELEMENTS,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [31:0]      wdata_i,
  input  logic [AddrW-1:0]        raddr_a_i,
  output logic signed [31:0]      rdata_a_o,
  input  logic [AddrW-1:0]        raddr_b_i,
  output logic signed [31:0]      rdata_b_o
);
  logic signed [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end
endmodule

[hw/rtl/mmvr_div.sv]
// Restoring divider: 64-bit unsigned dividend by a narrow divisor, one bit per cycle.
`timescale 1ns / 1ps
module mmvr_div #(
  parameter int unsigned DivW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [63:0]     dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [63:0]     quot_o
);
  logic [63:0]     a_q;
  logic [DivW-1:0] b_q, rem_q;
  logic [5:0]      it_q;
  logic            run_q, done_q;
  logic [DivW:0]   sh;
  logic            ge;

  assign sh = {rem_q, a_q[63]};
  assign ge = sh >= {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 6'd1;
        if (it_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= dividend_i;
      b_q   <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      // The dividend shifts out at the top while quotient bits shift in at the bottom.
      rem_q <= ge ? DivW'(sh - {1'b0, b_q}) : sh[DivW-1:0];
      a_q   <= {a_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = a_q;
endmodule

[hw/rtl/mmvr_sqrt.sv]
// Integer square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps
module mmvr_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] x_q, r_q, bit_q, t;
  logic [4:0]  it_q;
  logic        run_q, done_q;

  assign t = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 5'd1;
        if (it_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      x_q   <= rad_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (run_q) begin
      if (x_q >= t) begin
        x_q <= x_q - t;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];
endmodule

[hw/rtl/multi_mode_vector_reduction.sv]
// Top level of the multi-mode vector reduction block.
`timescale 1ns / 1ps
// Usage:
//   Samples enter on in_i when start is high and busy is low; each transfer stores
//   the sample and updates the running sum, product and nonzero count, or flags
//   overflow when full; then S_PROD does the registered Q32.16 product update.
//   The transfer marked last_sample starts the reduction selected by the
//   operation register (cfg_we_i / cfg_wdata_i, written while idle, reset 1).
//   After the last sample done_o is high for one cycle with the result, reached by:
//     sum, product, count nonzero, errors : straight from the product update
//     mean                                : one divide
//     max, min, argmax, argmin            : one memory scan
//     variance                            : divide, scan, divide
//     stdev                               : variance path plus a square root
//     median, mode                        : all pairs compared over the two
//                                           read ports
//   The receiver cannot hold results off; busy stays high until the result
//   transfer. Reset clears the vector state and sets the operation to sum;
//   the sample memory itself is not cleared.
module multi_mode_vector_reduction #(
  parameter int unsigned MaxElements = mmvr_pkg::MAX_ELEMENTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mmvr_pkg::in_t    in_i,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  output logic             done_o,
  output mmvr_pkg::out_t   result_o
);
  import mmvr_pkg::*;

  localparam int unsigned AW = $clog2(MaxElements);
  localparam int unsigned CW = $clog2(MaxElements + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PROD = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_PAIR = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q;
  op_e    op_q, opl_q;

  logic [CW-1:0]      cnt_q, nz_q;
  logic signed [47:0] sum_q, prod_q;
  logic               ovf_q, last_q, pen_q, pneg_q;
  logic [63:0]        phi_q, plo_q;

  logic signed [31:0] mean_q;
  logic               var_ph_q, div_go_q, sqrt_go_q;
  logic [63:0]        div_a_q, sqrt_a_q;
  logic [CW-1:0]      div_b_q;
  logic               div_done, sqrt_done;
  logic [63:0]        div_q;
  logic [31:0]        root;

  logic [AW-1:0]      i_q, j_q, ridx_q;
  logic               idone_q, rv_q, sqv_q;
  logic [47:0]        sq_q;
  logic [63:0]        sumsq_q;
  logic signed [31:0] ext_q, bestv_q, med_a_q, med_b_q;
  logic [AW-1:0]      exti_q;
  logic [CW-1:0]      lt_q, eq_q, best_q;

  logic signed [47:0] res_val_q;
  logic [10:0]        res_cnt_q;
  err_e               res_err_q;

  logic               accept, wr_en;
  logic [AW-1:0]      raddr_a;
  logic signed [31:0] rdata_a, rdata_b;

  // Product path: magnitudes split so each multiplier is 48 x 16.
  logic [47:0] pm;
  logic [31:0] xm;
  logic [63:0] m;
  logic signed [47:0] prod_nxt;

  assign accept = start && !busy;
  assign wr_en  = accept && (cnt_q != CW'(MaxElements));
  assign pm     = prod_q[47] ? 48'(-prod_q) : 48'(prod_q);
  assign xm     = in_i.sample[31] ? 32'(-in_i.sample) : 32'(in_i.sample);
  assign m      = phi_q + (plo_q >> 16);

  always_comb begin
    if (pneg_q) begin
      prod_nxt = (m >= 64'h0000_8000_0000_0000) ? SAT_LO : -$signed(48'(m));
    end else begin
      prod_nxt = (m > 64'(SAT_HI)) ? SAT_HI : $signed(48'(m));
    end
  end

  // Scan and pair helpers.
  logic               last_issue, last_outer, want_max, use_var;
  logic signed [32:0] d33;
  logic [31:0]        dm;
  logic [63:0]        sq;
  logic [64:0]        acc;
  logic [CW-1:0]      k1, k2;
  logic [CW:0]        lte;
  logic signed [32:0] msum;
  logic [CW-1:0]      nm1;

  assign nm1        = cnt_q - CW'(1);
  assign last_issue = CW'(j_q) == nm1;
  assign last_outer = CW'(i_q) == nm1;
  assign want_max   = (opl_q == OP_MAX) || (opl_q == OP_ARGMAX);
  assign use_var    = (opl_q == OP_STDEV) || (opl_q == OP_SSTDEV) || (opl_q == OP_VAR);
  assign d33        = 33'(rdata_a) - 33'(mean_q);
  assign dm         = d33[32] ? 32'(-d33) : d33[31:0];
  assign sq         = 64'(dm) * 64'(dm);
  assign acc        = {1'b0, sumsq_q} + {17'b0, sq_q};
  assign k2         = cnt_q >> 1;
  assign k1         = cnt_q[0] ? k2 : k2 - CW'(1);
  assign lte        = {1'b0, lt_q} + {1'b0, eq_q};
  assign msum       = 33'(med_a_q) + 33'(med_b_q);
  assign raddr_a    = (state_q == S_PAIR) ? i_q : j_q;

  function automatic logic [10:0] sat_cnt(input logic [31:0] v);
    sat_cnt = (v > 32'd2047) ? 11'h7FF : v[10:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_SUM;
      opl_q     <= OP_SUM;
      cnt_q     <= '0;
      nz_q      <= '0;
      sum_q     <= '0;
      prod_q    <= ONE_Q16;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      pen_q     <= 1'b0;
      var_ph_q  <= 1'b0;
      div_go_q  <= 1'b0;
      sqrt_go_q <= 1'b0;
      idone_q   <= 1'b0;
      rv_q      <= 1'b0;
      sqv_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      ridx_q    <= '0;
      mean_q    <= '0;
      div_a_q   <= '0;
      div_b_q   <= '0;
      sqrt_a_q  <= '0;
      sq_q      <= '0;
      sumsq_q   <= '0;
      ext_q     <= '0;
      exti_q    <= '0;
      bestv_q   <= '0;
      med_a_q   <= '0;
      med_b_q   <= '0;
      lt_q      <= '0;
      eq_q      <= '0;
      best_q    <= '0;
      res_val_q <= '0;
      res_cnt_q <= '0;
      res_err_q <= ERR_NONE;
    end else begin
      div_go_q  <= 1'b0;
      sqrt_go_q <= 1'b0;
      if (cfg_we_i) begin
        op_q <= op_e'(cfg_wdata_i);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            opl_q  <= op_q;
            last_q <= in_i.last_sample;
            pen_q  <= wr_en;
            if (wr_en) begin
              cnt_q <= cnt_q + CW'(1);
              sum_q <= sum_q + 48'(in_i.sample);
              if (in_i.sample != 32'sd0) begin
                nz_q <= nz_q + CW'(1);
              end
            end else begin
              ovf_q <= 1'b1;
            end
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          if (pen_q) begin
            prod_q <= prod_nxt;
          end
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            res_val_q <= '0;
            res_cnt_q <= '0;
            res_err_q <= ERR_NONE;
            state_q   <= S_OUT;
            if (opl_q == OP_NONE || opl_q > OP_CNTNZ) begin
              res_err_q <= ERR_MODE;
            end else if (ovf_q) begin
              res_err_q <= ERR_OVF;
            end else if (opl_q == OP_SSTDEV && cnt_q < CW'(2)) begin
              res_err_q <= ERR_ONE;
            end else begin
              unique case (opl_q)
                OP_SUM:   res_val_q <= sum_q;
                OP_PROD:  res_val_q <= pen_q ? prod_nxt : prod_q;
                OP_CNTNZ: res_cnt_q <= sat_cnt(32'(nz_q));
                OP_MEAN, OP_STDEV, OP_SSTDEV, OP_VAR: begin
                  div_a_q  <= 64'(sum_q[47] ? 48'(-sum_q) : 48'(sum_q));
                  div_b_q  <= cnt_q;
                  div_go_q <= 1'b1;
                  var_ph_q <= 1'b0;
                  state_q  <= S_DIV;
                end
                OP_MAX, OP_MIN, OP_ARGMAX, OP_ARGMIN: begin
                  j_q     <= '0;
                  idone_q <= 1'b0;
                  rv_q    <= 1'b0;
                  sqv_q   <= 1'b0;
                  state_q <= S_SCAN;
                end
                default: begin
                  // Median and mode compare every sample against every sample, itself included.
                  i_q     <= '0;
                  j_q     <= '0;
                  idone_q <= 1'b0;
                  rv_q    <= 1'b0;
                  lt_q    <= '0;
                  eq_q    <= '0;
                  best_q  <= '0;
                  state_q <= S_PAIR;
                end
              endcase
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!var_ph_q) begin
              mean_q <= sum_q[47] ? 32'(-div_q) : div_q[31:0];
              if (opl_q == OP_MEAN) begin
                res_val_q <= sum_q[47] ? -$signed(48'(div_q)) : $signed(48'(div_q));
                state_q   <= S_OUT;
              end else begin
                j_q     <= '0;
                idone_q <= 1'b0;
                rv_q    <= 1'b0;
                sqv_q   <= 1'b0;
                sumsq_q <= '0;
                state_q <= S_SCAN;
              end
            end else if (opl_q == OP_VAR) begin
              res_val_q <= (div_q > 64'(SAT_HI)) ? SAT_HI : $signed(div_q[47:0]);
              state_q   <= S_OUT;
            end else begin
              sqrt_a_q  <= (div_q[63:48] != 16'd0) ? {48'hFFFF_FFFF_FFFF, 16'd0}
                                                   : {div_q[47:0], 16'd0};
              sqrt_go_q <= 1'b1;
              state_q   <= S_SQRT;
            end
          end
        end
        S_SCAN: begin
          if (!idone_q) begin
            j_q <= j_q + AW'(1);
            if (last_issue) begin
              idone_q <= 1'b1;
            end
          end
          rv_q   <= !idone_q;
          ridx_q <= j_q;
          sqv_q  <= rv_q && use_var;
          if (rv_q) begin
            if (use_var) begin
              sq_q <= sq[63:16];
            end else if (ridx_q == '0 ||
                         (want_max ? rdata_a > ext_q : rdata_a < ext_q)) begin
              ext_q  <= rdata_a;
              exti_q <= ridx_q;
            end
          end
          if (sqv_q) begin
            sumsq_q <= acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
          end
          if (idone_q && !rv_q && !sqv_q) begin
            if (use_var) begin
              div_a_q  <= sumsq_q;
              div_b_q  <= (opl_q == OP_SSTDEV) ? nm1 : cnt_q;
              div_go_q <= 1'b1;
              var_ph_q <= 1'b1;
              state_q  <= S_DIV;
            end else begin
              if (opl_q == OP_MAX || opl_q == OP_MIN) begin
                res_val_q <= 48'(ext_q);
              end else begin
                res_cnt_q <= sat_cnt(32'(exti_q) + 32'd1);
              end
              state_q <= S_OUT;
            end
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            res_val_q <= $signed(48'(root));
            state_q   <= S_OUT;
          end
        end
        S_PAIR: begin
          // Port A holds the candidate; port B sweeps the whole vector against it.
          if (!idone_q) begin
            j_q <= j_q + AW'(1);
            if (last_issue) begin
              idone_q <= 1'b1;
            end
          end
          rv_q <= !idone_q;
          if (rv_q) begin
            if (rdata_b < rdata_a) begin
              lt_q <= lt_q + CW'(1);
            end
            if (rdata_b == rdata_a) begin
              eq_q <= eq_q + CW'(1);
            end
          end
          if (idone_q && !rv_q) begin
            if (lt_q <= k1 && {1'b0, k1} < lte) begin
              med_a_q <= rdata_a;
            end
            if (lt_q <= k2 && {1'b0, k2} < lte) begin
              med_b_q <= rdata_a;
            end
            if (eq_q > best_q || (eq_q == best_q && rdata_a < bestv_q)) begin
              best_q  <= eq_q;
              bestv_q <= rdata_a;
            end
            lt_q    <= '0;
            eq_q    <= '0;
            j_q     <= '0;
            idone_q <= 1'b0;
            rv_q    <= 1'b0;
            i_q     <= i_q + AW'(1);
            if (last_outer) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (opl_q == OP_MEDIAN) begin
            res_val_q <= 48'(msum >>> 1);
          end else begin
            res_val_q <= 48'(bestv_q);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          cnt_q   <= '0;
          nz_q    <= '0;
          sum_q   <= '0;
          prod_q  <= ONE_Q16;
          ovf_q   <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phi_q  <= 64'(pm) * 64'(xm[31:16]);
      plo_q  <= 64'(pm) * 64'(xm[15:0]);
      pneg_q <= prod_q[47] != in_i.sample[31];
    end
  end

  mmvr_store #(
    .Depth (MaxElements),
    .AddrW (AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (cnt_q[AW-1:0]),
    .wdata_i   (in_i.sample),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (j_q),
    .rdata_b_o (rdata_b)
  );

  mmvr_div #(
    .DivW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  mmvr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sqrt_go_q),
    .rad_i  (sqrt_a_q),
    .done_o (sqrt_done),
    .root_o (root)
  );

  assign busy                  = state_q != S_IDLE;
  assign done_o                = state_q == S_OUT;
  assign result_o.result_value = res_val_q;
  assign result_o.result_count = res_cnt_q;
  assign result_o.error_code   = res_err_q;
endmodule
